/* rtl/cfsd_pkg.sv */
// shared constants and types for the cached feature stream decoder
package cfsd_pkg;

	// index arithmetic width (16 to 32); the sum wraps at this many bits
	localparam int IndexBits = 32;

	// varint layout
	localparam int GroupBits = 7;
	localparam int MaxGroups = 5;
	localparam int AccBits   = GroupBits * MaxGroups;
	localparam int CntBits   = $clog2(MaxGroups + 1);

	// explicit value is four bytes, the last one completes the feature
	localparam int ValueBytes   = 4;
	localparam int ValueCntBits = $clog2(ValueBytes);
	localparam int ValueAccBits = 8 * (ValueBytes - 1);

	// value kind codes carried on the output tuser
	typedef enum logic [1:0] {
		KIND_PLUS_ONE  = 2'd0,
		KIND_MINUS_ONE = 2'd1,
		KIND_FLOAT     = 2'd2
	} value_kind_t;

endpackage

/* rtl/cached_feature_stream_decoder_unit.sv */
// top level: byte-serial varint feature decoder with a registered result stage
//
// channel  | direction | tdata                          | tuser
// s_axis   | in        | [7:0] code_byte                | [0] block_start
// m_axis   | out       | [31:0] feature_index,          | [1:0] value_kind
//          |           | [63:32] value_bits             |
// cfg      | in        | cfg_wdata = index_mask, cfg_we | -
//
// one byte is taken per cycle while s_axis_tready is high; the whole decode of a
// byte is one combinational pass from the decoder state into the result register,
// so a result appears in the cycle after the byte that completes a feature.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// after reset the index mask is all ones and all decoder state is clear.
module cached_feature_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
	input  logic        s_axis_tuser,   // [0] block_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] feature_index, [63:32] value_bits
	output logic [1:0]  m_axis_tuser,   // [1:0] value_kind
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import cfsd_pkg::*;

	// decoder state
	logic [31:0]             index_mask_q;
	logic [AccBits-1:0]      varint_acc_q;
	logic [CntBits-1:0]      varint_cnt_q;
	logic                    reading_value_q;
	logic [ValueCntBits-1:0] value_cnt_q;
	logic [ValueAccBits-1:0] value_acc_q;
	logic [31:0]             pending_index_q;
	logic [IndexBits-1:0]    prev_index_q;

	// result register
	logic        out_valid_s1;
	logic [31:0] out_index_s1;
	logic [31:0] out_bits_s1;
	value_kind_t out_kind_s1;

	// state seen by this beat, after a block start has cleared it
	logic [AccBits-1:0]      acc_eff;
	logic [CntBits-1:0]      cnt_eff;
	logic                    reading_eff;
	logic [ValueCntBits-1:0] vcnt_eff;
	logic [ValueAccBits-1:0] vacc_eff;
	logic [IndexBits-1:0]    prev_eff;

	// next state and result
	logic [AccBits-1:0]      acc_nxt;
	logic [CntBits-1:0]      cnt_nxt;
	logic                    reading_nxt;
	logic [ValueCntBits-1:0] vcnt_nxt;
	logic [ValueAccBits-1:0] vacc_nxt;
	logic [IndexBits-1:0]    prev_nxt;
	logic [31:0]             pending_nxt;
	logic                    emit;
	value_kind_t             kind_nxt;
	logic [31:0]             bits_nxt;

	// helpers
	logic [5:0]           acc_shift;
	logic [AccBits-1:0]   acc_grown;
	logic [31:0]          zz;
	logic [31:0]          delta;
	logic [IndexBits-1:0] idx_sum;
	logic                 accept;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_s1 || m_axis_tready;

	// block start clears the index and any partial feature
	always_comb begin
		if (s_axis_tuser) begin
			acc_eff     = '0;
			cnt_eff     = '0;
			reading_eff = 1'b0;
			vcnt_eff    = '0;
			vacc_eff    = '0;
			prev_eff    = '0;
		end else begin
			acc_eff     = varint_acc_q;
			cnt_eff     = varint_cnt_q;
			reading_eff = reading_value_q;
			vcnt_eff    = value_cnt_q;
			vacc_eff    = value_acc_q;
			prev_eff    = prev_index_q;
		end
	end

	// varint accumulation, saturating at the last group
	always_comb begin
		acc_shift = 6'(cnt_eff) * 6'(GroupBits);
		acc_grown = acc_eff;
		if (cnt_eff < CntBits'(MaxGroups)) begin
			acc_grown = acc_eff | (AccBits'(s_axis_tdata[GroupBits-1:0]) << acc_shift);
		end
	end

	// zigzag decode of the delta and the wrapped index sum
	always_comb begin
		zz      = acc_grown[33:2];
		delta   = (zz >> 1) ^ (32'd0 - {31'd0, zz[0]});
		idx_sum = prev_eff + delta[IndexBits-1:0];
	end

	// per-byte decode
	always_comb begin
		acc_nxt     = acc_eff;
		cnt_nxt     = cnt_eff;
		reading_nxt = reading_eff;
		vcnt_nxt    = vcnt_eff;
		vacc_nxt    = vacc_eff;
		prev_nxt    = prev_eff;
		pending_nxt = pending_index_q;
		emit        = 1'b0;
		kind_nxt    = KIND_PLUS_ONE;
		bits_nxt    = '0;
		if (reading_eff) begin
			if (vcnt_eff != ValueCntBits'(ValueBytes - 1)) begin
				vacc_nxt = vacc_eff | (ValueAccBits'(s_axis_tdata) << {vcnt_eff, 3'b000});
				vcnt_nxt = vcnt_eff + 1'b1;
			end else begin
				emit        = 1'b1;
				kind_nxt    = KIND_FLOAT;
				bits_nxt    = {s_axis_tdata, vacc_eff};
				reading_nxt = 1'b0;
				vcnt_nxt    = '0;
				vacc_nxt    = '0;
			end
		end else begin
			if (cnt_eff < CntBits'(MaxGroups)) begin
				cnt_nxt = cnt_eff + 1'b1;
			end
			acc_nxt = acc_grown;
			if (!s_axis_tdata[7]) begin
				// feature word complete
				prev_nxt    = idx_sum;
				pending_nxt = 32'(idx_sum) & index_mask_q;
				acc_nxt     = '0;
				cnt_nxt     = '0;
				if (acc_grown[0]) begin
					emit     = 1'b1;
					kind_nxt = KIND_MINUS_ONE;
				end else if (acc_grown[1]) begin
					reading_nxt = 1'b1;
				end else begin
					emit     = 1'b1;
					kind_nxt = KIND_PLUS_ONE;
				end
			end
		end
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_mask_q    <= '1;
			varint_acc_q    <= '0;
			varint_cnt_q    <= '0;
			reading_value_q <= 1'b0;
			value_cnt_q     <= '0;
			value_acc_q     <= '0;
			pending_index_q <= '0;
			prev_index_q    <= '0;
			out_valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				index_mask_q <= cfg_wdata;
			end
			if (accept) begin
				varint_acc_q    <= acc_nxt;
				varint_cnt_q    <= cnt_nxt;
				reading_value_q <= reading_nxt;
				value_cnt_q     <= vcnt_nxt;
				value_acc_q     <= vacc_nxt;
				pending_index_q <= pending_nxt;
				prev_index_q    <= prev_nxt;
				out_valid_s1    <= emit;
			end else if (m_axis_tready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	// result payload, loaded with each emitting beat
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_index_s1 <= pending_nxt;
			out_kind_s1  <= kind_nxt;
			out_bits_s1  <= bits_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_s1;
	assign m_axis_tdata  = {out_bits_s1, out_index_s1};
	assign m_axis_tuser  = out_kind_s1;

endmodule

/* rtl/cfsd_checker.sv */
// port-level checks for the decoder, bound to the top level
module cfsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import cfsd_pkg::*;

	// a stalled result holds its beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// only the three defined kinds appear
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == KIND_PLUS_ONE || m_axis_tuser == KIND_MINUS_ONE
			|| m_axis_tuser == KIND_FLOAT))
		else $error("undefined value kind");

	// value bits are zero unless an explicit value is carried
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_FLOAT |-> m_axis_tdata[63:32] == 32'd0)
		else $error("value bits set on unit value");

	// a new result comes only from a beat taken the cycle before
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("result without input beat");

	// an empty result stage never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind cached_feature_stream_decoder_unit cfsd_checker u_cfsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
